/* hw/rtl/pgm_header_parser_defines.svh */
// ----------------------------------------------------------------------------
// PGM header parser assertion macros
// Shared property forms for the checker of the header parser.
// ----------------------------------------------------------------------------
`ifndef PGM_HEADER_PARSER_DEFINES_SVH
`define PGM_HEADER_PARSER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PGMHP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PGMHP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pgmhp_pkg.sv */
// ----------------------------------------------------------------------------
// PGM header parser package
// Widths, character codes, error codes and the result type of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pgmhp_pkg;

   localparam int BYTE_BITS        = 8;
   localparam int COUNT_BITS       = 8;
   localparam int VALUE_BITS       = 16;
   localparam int MAX_DIGITS       = 31;
   localparam int DIGIT_COUNT_BITS = $clog2(MAX_DIGITS + 1);
   localparam int FIELD_BITS       = 16;
   localparam int CODE_BITS        = 4;

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_COUNT_IDX = '0;
   localparam logic [COUNT_BITS-1:0]     IMAGE_COUNT_RESET   = COUNT_BITS'(1);

   localparam logic [BYTE_BITS-1:0] CHAR_P     = 8'h50;
   localparam logic [BYTE_BITS-1:0] CHAR_5     = 8'h35;
   localparam logic [BYTE_BITS-1:0] CHAR_HASH  = 8'h23;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

   localparam logic [VALUE_BITS-1:0] WHITE_MAX = VALUE_BITS'(255);

   localparam logic [CODE_BITS-1:0] ERR_NONE          = 4'd0;
   localparam logic [CODE_BITS-1:0] ERR_BAD_MAGIC     = 4'd1;
   localparam logic [CODE_BITS-1:0] ERR_MISSING_NUM   = 4'd2;
   localparam logic [CODE_BITS-1:0] ERR_TOO_LONG      = 4'd3;
   localparam logic [CODE_BITS-1:0] ERR_PREMATURE_END = 4'd4;
   localparam logic [CODE_BITS-1:0] ERR_BAD_SIZE      = 4'd5;
   localparam logic [CODE_BITS-1:0] ERR_ZERO_WHITE    = 4'd6;
   localparam logic [CODE_BITS-1:0] ERR_WHITE_RANGE   = 4'd7;
   localparam logic [CODE_BITS-1:0] ERR_SHAPE         = 4'd8;

   typedef struct packed {
      logic                  header_done;
      logic                  header_failed;
      logic [CODE_BITS-1:0]  error_code;
      logic [FIELD_BITS-1:0] image_width;
      logic [FIELD_BITS-1:0] image_height;
      logic [FIELD_BITS-1:0] white_level;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/pgmhp_if.sv */
// ----------------------------------------------------------------------------
// PGM header parser channels
// Valid/ready channels for header bytes in and parse results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pgmhp_req_if;
   import pgmhp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pgmhp_rsp_if;
   import pgmhp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  header_done;
   logic                  header_failed;
   logic [CODE_BITS-1:0]  error_code;
   logic [FIELD_BITS-1:0] image_width;
   logic [FIELD_BITS-1:0] image_height;
   logic [FIELD_BITS-1:0] white_level;

   modport source (output valid, output header_done, output header_failed,
                   output error_code, output image_width, output image_height,
                   output white_level, input ready);
   modport sink (input valid, input header_done, input header_failed,
                 input error_code, input image_width, input image_height,
                 input white_level, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pgmhp_parse_core.sv */
// ----------------------------------------------------------------------------
// PGM header parse core
// Byte-wise header state machine with decimal accumulation and final checks.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmhp_parse_core
   import pgmhp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [BYTE_BITS-1:0]  data_byte,
   input  logic                  end_of_stream,
   input  logic [COUNT_BITS-1:0] image_count,
   output result_type            result
);

   typedef enum logic [3:0] {
      PH_MAGIC_P,
      PH_MAGIC_5,
      PH_MAGIC_END,
      PH_SKIP_W,
      PH_DIG_W,
      PH_SKIP_H,
      PH_DIG_H,
      PH_SKIP_X,
      PH_DIG_X,
      PH_DONE,
      PH_FAILED
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic                        comment_ff, comment_in;
   logic [DIGIT_COUNT_BITS-1:0] count_ff, count_in;
   logic [VALUE_BITS-1:0]       acc_ff, acc_in;
   logic [VALUE_BITS-1:0]       width_ff, width_in;
   logic [VALUE_BITS-1:0]       height_ff, height_in;
   logic [VALUE_BITS-1:0]       white_ff, white_in;
   logic [CODE_BITS-1:0]        error_ff, error_in;

   logic [VALUE_BITS+3:0]            acc_next_wide;
   logic [VALUE_BITS+COUNT_BITS-1:0] shape_product;
   logic                             too_long;
   logic                             byte_ws;
   logic                             byte_digit;
   logic                             byte_hash;
   logic                             byte_eol;
   logic [VALUE_BITS-1:0]            digit_value;

   assign byte_ws    = (data_byte == CHAR_SPACE) ||
                       ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
   assign byte_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign byte_hash  = (data_byte == CHAR_HASH);
   assign byte_eol   = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);
   assign digit_value = VALUE_BITS'(data_byte[3:0]);

   assign acc_next_wide = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                        + (VALUE_BITS + 4)'(data_byte[3:0]);
   assign too_long = (count_ff >= DIGIT_COUNT_BITS'(MAX_DIGITS)) ||
                     (acc_next_wide[VALUE_BITS+3:VALUE_BITS] != 4'b0);
   assign shape_product = (VALUE_BITS + COUNT_BITS)'(height_ff)
                        * (VALUE_BITS + COUNT_BITS)'(image_count);

   always_comb begin
      phase_in   = phase_ff;
      comment_in = comment_ff;
      count_in   = count_ff;
      acc_in     = acc_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      white_in   = white_ff;
      error_in   = error_ff;
      if (accept && (phase_ff != PH_DONE) && (phase_ff != PH_FAILED)) begin
         if (end_of_stream) begin
            phase_in = PH_FAILED;
            if ((phase_ff == PH_MAGIC_P) || (phase_ff == PH_MAGIC_5) ||
                (phase_ff == PH_MAGIC_END)) begin
               error_in = ERR_BAD_MAGIC;
            end else if (phase_ff == PH_DIG_X) begin
               error_in = ERR_PREMATURE_END;
            end else begin
               error_in = ERR_MISSING_NUM;
            end
         end else begin
            unique case (phase_ff)
               PH_MAGIC_P: begin
                  if (data_byte == CHAR_P) begin
                     phase_in = PH_MAGIC_5;
                  end else begin
                     phase_in = PH_FAILED;
                     error_in = ERR_BAD_MAGIC;
                  end
               end
               PH_MAGIC_5: begin
                  if (data_byte == CHAR_5) begin
                     phase_in = PH_MAGIC_END;
                  end else begin
                     phase_in = PH_FAILED;
                     error_in = ERR_BAD_MAGIC;
                  end
               end
               PH_MAGIC_END: begin
                  if (byte_ws) begin
                     phase_in = PH_SKIP_W;
                  end else begin
                     phase_in = PH_FAILED;
                     error_in = ERR_BAD_MAGIC;
                  end
               end
               PH_SKIP_W, PH_SKIP_H, PH_SKIP_X: begin
                  if (comment_ff) begin
                     if (byte_eol) begin
                        comment_in = 1'b0;
                     end
                  end else if (byte_ws) begin
                     comment_in = 1'b0;
                  end else if (byte_hash) begin
                     comment_in = 1'b1;
                  end else if (byte_digit) begin
                     acc_in   = digit_value;
                     count_in = DIGIT_COUNT_BITS'(1);
                     if (phase_ff == PH_SKIP_W) begin
                        phase_in = PH_DIG_W;
                     end else if (phase_ff == PH_SKIP_H) begin
                        phase_in = PH_DIG_H;
                     end else begin
                        phase_in = PH_DIG_X;
                     end
                  end else begin
                     phase_in = PH_FAILED;
                     error_in = ERR_MISSING_NUM;
                  end
               end
               PH_DIG_W, PH_DIG_H, PH_DIG_X: begin
                  if (byte_digit) begin
                     if (too_long) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_TOO_LONG;
                     end else begin
                        acc_in   = acc_next_wide[VALUE_BITS-1:0];
                        count_in = count_ff + DIGIT_COUNT_BITS'(1);
                     end
                  end else if (phase_ff == PH_DIG_X) begin
                     white_in = acc_ff;
                     if ((width_ff == '0) || (height_ff == '0)) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_BAD_SIZE;
                     end else if (acc_ff == '0) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_ZERO_WHITE;
                     end else if (acc_ff > WHITE_MAX) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_WHITE_RANGE;
                     end else if (shape_product !=
                                  (VALUE_BITS + COUNT_BITS)'(width_ff)) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_SHAPE;
                     end else begin
                        phase_in = PH_DONE;
                     end
                  end else begin
                     if (phase_ff == PH_DIG_W) begin
                        width_in = acc_ff;
                     end else begin
                        height_in = acc_ff;
                     end
                     if (byte_ws || byte_hash) begin
                        comment_in = byte_hash;
                        phase_in   = (phase_ff == PH_DIG_W) ? PH_SKIP_H : PH_SKIP_X;
                     end else begin
                        phase_in = PH_FAILED;
                        error_in = ERR_MISSING_NUM;
                     end
                  end
               end
               default: begin
                  phase_in = PH_FAILED;
                  error_in = ERR_BAD_MAGIC;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC_P;
         comment_ff <= 1'b0;
         count_ff   <= '0;
         acc_ff     <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         white_ff   <= '0;
         error_ff   <= ERR_NONE;
      end else begin
         phase_ff   <= phase_in;
         comment_ff <= comment_in;
         count_ff   <= count_in;
         acc_ff     <= acc_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         white_ff   <= white_in;
         error_ff   <= error_in;
      end
   end

   always_comb begin
      result.header_done   = (phase_in == PH_DONE);
      result.header_failed = (phase_in == PH_FAILED);
      result.error_code    = error_in;
      result.image_width   = FIELD_BITS'(width_in);
      result.image_height  = FIELD_BITS'(height_in);
      result.white_level   = FIELD_BITS'(white_in);
   end

endmodule

`default_nettype wire

/* hw/rtl/pgm_header_parser.sv */
// ----------------------------------------------------------------------------
// PGM header parser
// Parses the header of a binary grey-map stream and checks its dimensions.
// ----------------------------------------------------------------------------
// Header bytes enter on req_if, one byte or one end mark per transfer. Every
// accepted transfer yields exactly one transfer on rsp_if with the status and
// the values parsed so far. The result is registered, and a new byte can be
// taken in every cycle while req_if.ready is high: the parse state and the
// multiply-by-ten digit update are both combinational from registered state.
// The result side has an output register and a one-entry skid buffer, so the
// input keeps taking bytes while one result waits; req_if.ready drops only when
// both are full, and rises again the cycle after rsp_if takes a result.
// image_count is written over the APB port at byte address 0 and is read when
// the maximum value ends; write it only while the parser is idle.
// Reset brings the parser back to expecting the magic, clears all values and
// errors, sets image_count to 1 and empties the result buffers. After success
// or the first error the status holds until the next reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_header_parser
   import pgmhp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   pgmhp_req_if.sink                req_if,
   pgmhp_rsp_if.source              rsp_if,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [COUNT_BITS-1:0] image_count_ff, image_count_in;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic csr_write;

   result_type core_result;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic out_valid_ff, out_valid_in;
   logic skid_valid_ff, skid_valid_in;
   logic req_accept;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      image_count_in = image_count_ff;
      prdata         = '0;
      unique case (csr_index)
         CSR_IMAGE_COUNT_IDX: begin
            prdata = CSR_DATA_BITS'(image_count_ff);
            if (csr_write) begin
               image_count_in = pwdata[COUNT_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign req_if.ready = !skid_valid_ff;
   assign req_accept   = req_if.valid && !skid_valid_ff;

   pgmhp_parse_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .data_byte     (req_if.data_byte),
      .end_of_stream (req_if.end_of_stream),
      .image_count   (image_count_ff),
      .result        (core_result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = skid_valid_ff;
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end
      if (req_accept) begin
         if (!out_valid_in) begin
            out_in       = core_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = core_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_count_ff <= IMAGE_COUNT_RESET;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         image_count_ff <= image_count_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.header_done   = out_ff.header_done;
   assign rsp_if.header_failed = out_ff.header_failed;
   assign rsp_if.error_code    = out_ff.error_code;
   assign rsp_if.image_width   = out_ff.image_width;
   assign rsp_if.image_height  = out_ff.image_height;
   assign rsp_if.white_level   = out_ff.white_level;

endmodule

`default_nettype wire

/* hw/rtl/pgmhp_checker.sv */
// ----------------------------------------------------------------------------
// PGM header parser checker
// Assertions on the result channel of the header parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pgm_header_parser_defines.svh"

module pgmhp_checker
   import pgmhp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  header_done,
   input logic                  header_failed,
   input logic [CODE_BITS-1:0]  error_code,
   input logic [FIELD_BITS-1:0] image_width,
   input logic [FIELD_BITS-1:0] image_height,
   input logic [FIELD_BITS-1:0] white_level
);

   logic seen_failed_ff, seen_failed_in;
   logic seen_done_ff, seen_done_in;

   assign seen_failed_in = seen_failed_ff || (rsp_valid && rsp_ready && header_failed);
   assign seen_done_in   = seen_done_ff || (rsp_valid && rsp_ready && header_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_failed_ff <= 1'b0;
         seen_done_ff   <= 1'b0;
      end else begin
         seen_failed_ff <= seen_failed_in;
         seen_done_ff   <= seen_done_in;
      end
   end

   `PGMHP_ASSERT_SAME(a_status_exclusive, rsp_valid, !(header_done && header_failed), "done and failed together")

   `PGMHP_ASSERT_SAME(a_code_matches_failed, rsp_valid, header_failed == (error_code != ERR_NONE), "error code disagrees with failed flag")

   `PGMHP_ASSERT_SAME(a_final_status_sticky, rsp_valid && (seen_failed_ff || seen_done_ff), (header_failed == seen_failed_ff) && (header_done == seen_done_ff), "final status changed")

   `PGMHP_ASSERT_NEXT(a_stalled_result_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(error_code) && $stable(image_width) && $stable(image_height) && $stable(white_level), "stalled result changed")

endmodule

bind pgm_header_parser pgmhp_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .header_done   (rsp_if.header_done),
   .header_failed (rsp_if.header_failed),
   .error_code    (rsp_if.error_code),
   .image_width   (rsp_if.image_width),
   .image_height  (rsp_if.image_height),
   .white_level   (rsp_if.white_level)
);

`default_nettype wire
